[hw/rtl/rwlt_pkg.sv]
`timescale 1ns / 1ps

package rwlt_pkg;

    // request opcodes
    localparam logic [2:0] OP_OPEN         = 3'd0;
    localparam logic [2:0] OP_READ_LOCK    = 3'd1;
    localparam logic [2:0] OP_READ_UNLOCK  = 3'd2;
    localparam logic [2:0] OP_WRITE_LOCK   = 3'd3;
    localparam logic [2:0] OP_WRITE_UNLOCK = 3'd4;
    localparam logic [2:0] OP_CLOSE        = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXISTS   = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_LOCKED   = 3'd3;
    localparam logic [2:0] ST_STATE    = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // lock modes held per entry
    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] handle;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } dp_sts_t;

endpackage

[hw/rtl/rwlt_ctrl.sv]
`timescale 1ns / 1ps

module rwlt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rwlt_pkg::dp_cmd_t cmd,
    input  rwlt_pkg::dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    // output slot can take a new item this cycle
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[hw/rtl/rwlt_datapath.sv]
`timescale 1ns / 1ps

module rwlt_datapath
#(
    parameter int LOCK_ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rwlt_pkg::req_t    req,
    output rwlt_pkg::rsp_t    rsp,
    input  rwlt_pkg::dp_cmd_t cmd,
    output rwlt_pkg::dp_sts_t sts
);

    localparam int IDX_W = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_ENTRIES - 1);

    // key and mode storage, valid bits in flops
    logic [63:0]             key_mem [LOCK_ENTRIES];
    logic [1:0]              mode_mem [LOCK_ENTRIES];
    logic [LOCK_ENTRIES-1:0] valid_reg;

    rwlt_pkg::req_t   req_reg;
    rwlt_pkg::rsp_t   rsp_reg;
    logic [IDX_W-1:0] scan_cnt_reg;
    logic [63:0]      rd_key_reg;
    logic [1:0]       rd_mode_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [1:0]       match_mode_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             hit;
    logic             empty;
    rwlt_pkg::rsp_t   rsp_next;
    logic             wr_key_en;
    logic             wr_mode_en;
    logic [IDX_W-1:0] wr_idx;
    logic [1:0]       wr_mode;
    logic             set_valid;
    logic             clr_valid;
    logic [2:0]       status;

    assign sts.scan_last = (scan_cnt_reg == LAST_IDX);

    // request latch and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan_en;
            if (cmd.load || (cmd.scan_en && sts.scan_last))
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        cmp_idx_reg <= scan_cnt_reg;
    end

    // memory read port, one entry per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            rd_key_reg  <= key_mem[scan_cnt_reg];
            rd_mode_reg <= mode_mem[scan_cnt_reg];
        end
    end

    // compare stage
    assign hit   = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_key_reg == req_reg.handle);
    assign empty = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    // lowest matching entry and lowest empty slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            if (hit && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (empty && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && !match_found_reg)
        begin
            match_idx_reg  <= cmp_idx_reg;
            match_mode_reg <= rd_mode_reg;
        end
        if (empty && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // request decision
    always_comb
    begin
        status     = rwlt_pkg::ST_OK;
        wr_key_en  = 1'b0;
        wr_mode_en = 1'b0;
        wr_idx     = match_idx_reg;
        wr_mode    = rwlt_pkg::MODE_FREE;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        case (req_reg.opcode)
            rwlt_pkg::OP_OPEN:
            begin
                wr_idx = free_idx_reg;
                if (match_found_reg)
                begin
                    status = rwlt_pkg::ST_EXISTS;
                end
                else if (!free_found_reg)
                begin
                    status = rwlt_pkg::ST_FULL;
                end
                else
                begin
                    wr_key_en  = 1'b1;
                    wr_mode_en = 1'b1;
                    set_valid  = 1'b1;
                end
            end
            rwlt_pkg::OP_CLOSE:
            begin
                clr_valid = match_found_reg;
            end
            rwlt_pkg::OP_READ_LOCK:
            begin
                if (!match_found_reg)
                begin
                    status = rwlt_pkg::ST_NOTFOUND;
                end
                else if (match_mode_reg == rwlt_pkg::MODE_WRITE)
                begin
                    status = rwlt_pkg::ST_LOCKED;
                end
                else
                begin
                    wr_mode_en = 1'b1;
                    wr_mode    = rwlt_pkg::MODE_READ;
                end
            end
            rwlt_pkg::OP_READ_UNLOCK:
            begin
                if (!match_found_reg)
                begin
                    status = rwlt_pkg::ST_NOTFOUND;
                end
                else if (match_mode_reg != rwlt_pkg::MODE_READ)
                begin
                    status = rwlt_pkg::ST_STATE;
                end
                else
                begin
                    wr_mode_en = 1'b1;
                end
            end
            rwlt_pkg::OP_WRITE_LOCK:
            begin
                if (!match_found_reg)
                begin
                    status = rwlt_pkg::ST_NOTFOUND;
                end
                else if (match_mode_reg == rwlt_pkg::MODE_READ ||
                         match_mode_reg == rwlt_pkg::MODE_WRITE)
                begin
                    status = rwlt_pkg::ST_LOCKED;
                end
                else
                begin
                    wr_mode_en = 1'b1;
                    wr_mode    = rwlt_pkg::MODE_WRITE;
                end
            end
            rwlt_pkg::OP_WRITE_UNLOCK:
            begin
                if (!match_found_reg)
                begin
                    status = rwlt_pkg::ST_NOTFOUND;
                end
                else if (match_mode_reg != rwlt_pkg::MODE_WRITE)
                begin
                    status = rwlt_pkg::ST_STATE;
                end
                else
                begin
                    wr_mode_en = 1'b1;
                end
            end
            default:
            begin
                status = rwlt_pkg::ST_STATE;
            end
        endcase
        rsp_next.ok     = (status == rwlt_pkg::ST_OK);
        rsp_next.status = status;
    end

    // table update on commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_key_en)
        begin
            key_mem[wr_idx] <= req_reg.handle;
        end
        if (cmd.commit && wr_mode_en)
        begin
            mode_mem[wr_idx] <= wr_mode;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

[hw/rtl/rw_lock_table_top.sv]
`timescale 1ns / 1ps

// channel  | valid     | ready     | payload
// ---------+-----------+-----------+----------------------------
// request  | req_valid | req_ready | req (opcode, handle)
// result   | rsp_valid | rsp_ready | rsp (ok, status)
//
// each item passes an accept state, a scan through the key/mode memory
// read port at one entry per cycle, a compare drain state and an update
// state.
// reset clears all valid bits at once; no clearing pass is needed.
// a finished result waits in the output register while the next item is
// accepted; only the update cycle stalls until that register is free.

module rw_lock_table_top
#(
    parameter int LOCK_ENTRIES = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rwlt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rwlt_pkg::rsp_t rsp
);

    rwlt_pkg::dp_cmd_t cmd;
    rwlt_pkg::dp_sts_t sts;

    rwlt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rwlt_datapath #(
        .LOCK_ENTRIES (LOCK_ENTRIES)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

    // one item in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another item is in flight");

    // ok bit agrees with status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.ok == (rsp.status == rwlt_pkg::ST_OK)))
        else $error("ok bit disagrees with status");

    // status always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= rwlt_pkg::ST_FULL))
        else $error("undefined status code");

    // a result never appears in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
        else $error("result produced without a table scan");

endmodule

[bench/tb_rw_lock_table_top.sv]
`timescale 1ns / 1ps

module tb_rw_lock_table_top;

    localparam int LOCK_ENTRIES = 16;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 900;
    localparam int STEADY_FIRST = 300;
    localparam int STEADY_LAST  = 480;
    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    // opcodes outside the defined set; the block answers wrong state
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [63:0] HANDLE_ZERO = 64'd0;
    localparam logic [63:0] HANDLE_MAX  = {64{1'b1}};

    // lock table mirror and queue of pending responses
    class lock_table_scoreboard;
        bit             in_use [LOCK_ENTRIES];
        logic [63:0]    key_of [LOCK_ENTRIES];
        logic [1:0]     mode_of[LOCK_ENTRIES];
        rwlt_pkg::rsp_t pending_rsp_q[$];
        int             errors;

        function new();
            for (int i = 0; i < LOCK_ENTRIES; i++)
            begin
                in_use[i]  = 1'b0;
                key_of[i]  = '0;
                mode_of[i] = rwlt_pkg::MODE_FREE;
            end
            errors = 0;
        endfunction

        // lowest valid entry holding this key, -1 if none
        function int find_key(logic [63:0] handle);
            for (int i = 0; i < LOCK_ENTRIES; i++)
                if (in_use[i] && key_of[i] == handle)
                    return i;
            return -1;
        endfunction

        // apply one request to the mirror and return its status
        function logic [2:0] resolve_request(rwlt_pkg::req_t r);
            int idx;
            int slot;
            idx  = find_key(r.handle);
            slot = -1;
            if (r.opcode == OP_SPARE_6 || r.opcode == OP_SPARE_7)
                return rwlt_pkg::ST_STATE;
            case (r.opcode)
                rwlt_pkg::OP_OPEN:
                begin
                    if (idx >= 0)
                        return rwlt_pkg::ST_EXISTS;
                    for (int i = 0; i < LOCK_ENTRIES && slot < 0; i++)
                        if (!in_use[i])
                            slot = i;
                    if (slot < 0)
                        return rwlt_pkg::ST_FULL;
                    in_use[slot]  = 1'b1;
                    key_of[slot]  = r.handle;
                    mode_of[slot] = rwlt_pkg::MODE_FREE;
                    return rwlt_pkg::ST_OK;
                end
                rwlt_pkg::OP_CLOSE:
                begin
                    if (idx >= 0)
                        in_use[idx] = 1'b0;
                    return rwlt_pkg::ST_OK;
                end
                default: ;
            endcase
            if (idx < 0)
                return rwlt_pkg::ST_NOTFOUND;
            case (r.opcode)
                rwlt_pkg::OP_READ_LOCK:
                begin
                    if (mode_of[idx] == rwlt_pkg::MODE_WRITE)
                        return rwlt_pkg::ST_LOCKED;
                    mode_of[idx] = rwlt_pkg::MODE_READ;
                end
                rwlt_pkg::OP_READ_UNLOCK:
                begin
                    if (mode_of[idx] != rwlt_pkg::MODE_READ)
                        return rwlt_pkg::ST_STATE;
                    mode_of[idx] = rwlt_pkg::MODE_FREE;
                end
                rwlt_pkg::OP_WRITE_LOCK:
                begin
                    if (mode_of[idx] == rwlt_pkg::MODE_READ ||
                        mode_of[idx] == rwlt_pkg::MODE_WRITE)
                        return rwlt_pkg::ST_LOCKED;
                    mode_of[idx] = rwlt_pkg::MODE_WRITE;
                end
                default:
                begin
                    if (mode_of[idx] != rwlt_pkg::MODE_WRITE)
                        return rwlt_pkg::ST_STATE;
                    mode_of[idx] = rwlt_pkg::MODE_FREE;
                end
            endcase
            return rwlt_pkg::ST_OK;
        endfunction

        // accepted request: predict and queue its response
        function void note_request(rwlt_pkg::req_t r);
            rwlt_pkg::rsp_t e;
            e.status = resolve_request(r);
            e.ok     = (e.status == rwlt_pkg::ST_OK);
            pending_rsp_q.push_back(e);
        endfunction

        // accepted response: compare with the oldest prediction
        function void check_result(rwlt_pkg::rsp_t got);
            rwlt_pkg::rsp_t e;
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected response ok=%0d status=%0d", got.ok, got.status);
                errors++;
                return;
            end
            e = pending_rsp_q.pop_front();
            if (got.ok !== e.ok)
            begin
                $error("ok: expected %0d, actual %0d", e.ok, got.ok);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    rwlt_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    rwlt_pkg::rsp_t rsp;

    lock_table_scoreboard sb;
    logic [63:0]          handle_pool[POOL_SIZE];
    bit                   steady;
    int                   cycle_count;

    rw_lock_table_top #(.LOCK_ENTRIES(LOCK_ENTRIES)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[rw_lock_table_top] ERROR");
            $finish;
        end
    end

    // response side: check accepted items, stall at random outside the steady window
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_result(rsp);
            rsp_ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // drive one request item and wait for it to be taken
    task automatic send_req(input logic [2:0] op, input logic [63:0] handle);
        rwlt_pkg::req_t r;
        r.opcode = op;
        r.handle = handle;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // choose the next item, mostly legal steps on handles from the pool
    task automatic pick_item(output logic [2:0] op, output logic [63:0] handle);
        int roll;
        int p;
        int idx;
        roll = $urandom_range(99);
        p    = $urandom_range(POOL_SIZE - 1);
        if (roll < 8)
        begin
            // noise, unused opcodes included
            op     = 3'($urandom_range(7));
            handle = {$urandom, $urandom};
        end
        else if (roll < 14)
        begin
            // near miss: one bit away from a pool key
            op     = 3'($urandom_range(rwlt_pkg::OP_CLOSE, rwlt_pkg::OP_READ_LOCK));
            handle = handle_pool[p] ^ (64'd1 << $urandom_range(63));
        end
        else
        begin
            idx = sb.find_key(handle_pool[p]);
            if (idx < 0)
            begin
                if ($urandom_range(15) == 0)
                    handle_pool[p] = {$urandom, $urandom};
                if ($urandom_range(9) < 8)
                    op = rwlt_pkg::OP_OPEN;
                else
                    op = 3'($urandom_range(rwlt_pkg::OP_CLOSE, rwlt_pkg::OP_READ_LOCK));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                    op = rwlt_pkg::OP_CLOSE;
                else if (roll < 25)
                    op = 3'($urandom_range(rwlt_pkg::OP_CLOSE, rwlt_pkg::OP_OPEN));
                else
                    case (sb.mode_of[idx])
                        rwlt_pkg::MODE_FREE:
                            op = $urandom_range(1) ? rwlt_pkg::OP_READ_LOCK
                                                   : rwlt_pkg::OP_WRITE_LOCK;
                        rwlt_pkg::MODE_READ:
                            op = $urandom_range(1) ? rwlt_pkg::OP_READ_UNLOCK
                                                   : rwlt_pkg::OP_READ_LOCK;
                        default:
                            op = rwlt_pkg::OP_WRITE_UNLOCK;
                    endcase
            end
            handle = handle_pool[p];
        end
    endtask

    // main sequence
    initial
    begin
        logic [2:0]  op;
        logic [63:0] handle;
        sb        = new();
        steady    = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        handle_pool[0] = HANDLE_ZERO;
        handle_pool[1] = HANDLE_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            handle_pool[i] = {$urandom, $urandom};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every opcode and every status but full on the extreme handles
        send_req(rwlt_pkg::OP_OPEN,         HANDLE_ZERO);
        send_req(rwlt_pkg::OP_OPEN,         HANDLE_ZERO);
        send_req(rwlt_pkg::OP_READ_LOCK,    HANDLE_MAX);
        send_req(rwlt_pkg::OP_READ_LOCK,    HANDLE_ZERO);
        send_req(rwlt_pkg::OP_READ_LOCK,    HANDLE_ZERO);
        send_req(rwlt_pkg::OP_WRITE_LOCK,   HANDLE_ZERO);
        send_req(rwlt_pkg::OP_WRITE_UNLOCK, HANDLE_ZERO);
        send_req(rwlt_pkg::OP_READ_UNLOCK,  HANDLE_ZERO);
        send_req(rwlt_pkg::OP_READ_UNLOCK,  HANDLE_ZERO);
        send_req(rwlt_pkg::OP_WRITE_LOCK,   HANDLE_ZERO);
        send_req(rwlt_pkg::OP_READ_LOCK,    HANDLE_ZERO);
        send_req(rwlt_pkg::OP_WRITE_LOCK,   HANDLE_ZERO);
        send_req(rwlt_pkg::OP_WRITE_UNLOCK, HANDLE_ZERO);
        send_req(OP_SPARE_6,                HANDLE_ZERO);
        send_req(OP_SPARE_7,                HANDLE_MAX);
        send_req(rwlt_pkg::OP_CLOSE,        HANDLE_MAX);
        send_req(rwlt_pkg::OP_OPEN,         HANDLE_MAX);
        send_req(rwlt_pkg::OP_WRITE_LOCK,   HANDLE_MAX);
        send_req(rwlt_pkg::OP_CLOSE,        HANDLE_ZERO);
        send_req(rwlt_pkg::OP_READ_LOCK,    HANDLE_ZERO);
        send_req(rwlt_pkg::OP_CLOSE,        HANDLE_MAX);

        // random traffic; the pool is larger than the table so it fills up
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= STEADY_FIRST && n < STEADY_LAST);
            pick_item(op, handle);
            send_req(op, handle);
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        // drain
        while (sb.pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_rsp_q.size() != 0)
        begin
            $error("%0d responses never arrived", sb.pending_rsp_q.size());
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("[rw_lock_table_top] OK");
        else
            $display("[rw_lock_table_top] ERROR");
        $finish;
    end

endmodule
